// ----- rtl/pwsn_pkg.sv -----
// Package for the per-well size table normaliser: widths, codes and types.
package pwsn_pkg;

  localparam int RowBits   = 6;
  localparam int ColBits   = 6;
  localparam int AddrBits  = RowBits + ColBits;
  localparam int Wells     = 1 << AddrBits;
  localparam int ValueBits = 26;
  localparam int WordBits  = ValueBits + 1;     // present flag above the value
  localparam int CntBits   = AddrBits + 1;      // well count, up to Wells
  localparam int SumBits   = ValueBits + AddrBits;
  localparam int SqBits    = 2 * ValueBits + AddrBits;
  localparam int CBits     = 36;                // normalising constant, 8 frac bits
  localparam int DivBits   = 96;
  localparam int MulBits   = 80;
  localparam int MulIters  = SumBits;
  localparam int SqrtBits  = 68;                // variance, 16 frac bits
  localparam int RootBits  = SqrtBits / 2;
  localparam int NormBits  = 17;
  localparam int InDataW   = 168;
  localparam int OutDataW  = 80;

  localparam logic [ValueBits-1:0] ValueMax = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_MAX    = 2'd0,
    MODE_TOTAL  = 2'd1,
    MODE_PASSES = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [12:0] {
    S_CLR      = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_ADD_RD   = 13'b0000000000100,
    S_ADD_MUL  = 13'b0000000001000,
    S_ADD_WR   = 13'b0000000010000,
    S_FIN_WALK = 13'b0000000100000,
    S_SEQ      = 13'b0000001000000,
    S_MUL      = 13'b0000010000000,
    S_DIV      = 13'b0000100000000,
    S_SQRT     = 13'b0001000000000,
    S_RD_RD    = 13'b0010000000000,
    S_RD_CHK   = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  typedef enum logic [6:0] {
    P_MEAN = 7'b0000001,
    P_NN   = 7'b0000010,
    P_NQ   = 7'b0000100,
    P_SS   = 7'b0001000,
    P_VAR  = 7'b0010000,
    P_SQRT = 7'b0100000,
    P_DONE = 7'b1000000
  } phase_t;

endpackage

// ----- rtl/pwsn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pwsn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/per_well_size_table_normalizer_top.sv -----
// Top level of the per-well size table normaliser.
//
// Usage. Items arrive on the s_axis channel; tuser carries the operation
// (add record, finish, read next cell, clear table), tdata the record fields.
// Only "read next cell" gives a result item on m_axis, with tlast set on the
// final cell of the grid. cfg_we/cfg_wdata set the accumulate mode; the user
// is to write it only while the block is idle, which the block does not enforce.
// Timing. One item is worked on at a time; s_axis_tready is high only when
// the sequencer is idle. Add record: RAM read, multiply, write.
// Finish: a table walk, one well a cycle through the RAM read port, then
// bit-serial arithmetic on the shared divide, multiply and root units
// (mean, n*n, n*Q, S*S, variance, root).
// Read cell: RAM read and check, plus a 96-step division when one is needed.
// Clear: one RAM word a cycle over all 4096 words.
// Reset. After rst the block runs the same clearing pass over the well RAM
// before it takes any item; configuration writes are taken meanwhile.
// Stall. The result sits in an output register; while it waits the block
// still takes items, and a further read only holds in its last state until
// the register frees.
module per_well_size_table_normalizer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,      // accumulate_mode
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // well_row[15:0] well_col[31:16] has_query_bounds[32] query_start[64:33]
  // query_end[96:65] sequence_length[128:97] has_passes[129] num_passes[161:130]
  input  logic [pwsn_pkg::InDataW-1:0] s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,   // operation
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // cell_row[5:0] cell_col[11:6] normalized_value[28:12] grid_rows[35:29]
  // grid_cols[42:36] dropped_records[74:43]
  output logic [pwsn_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast   // last_cell
);
  import pwsn_pkg::*;

  // input field views
  logic [15:0] in_row, in_col;
  logic        in_hq, in_hp;
  logic [31:0] in_qs, in_qe, in_seq, in_np, in_size;
  assign in_row = s_axis_tdata[15:0];
  assign in_col = s_axis_tdata[31:16];
  assign in_hq  = s_axis_tdata[32];
  assign in_qs  = s_axis_tdata[64:33];
  assign in_qe  = s_axis_tdata[96:65];
  assign in_seq = s_axis_tdata[128:97];
  assign in_hp  = s_axis_tdata[129];
  assign in_np  = s_axis_tdata[161:130];
  assign in_size = in_hq ? ((in_qs < in_qe) ? in_qe - in_qs : in_qs - in_qe) : in_seq;

  state_t state;
  phase_t phase;
  mode_t  mode;

  logic in_acc;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // record latches
  logic [AddrBits-1:0] add_idx;
  logic [31:0]         add_size, add_np;
  logic                add_hp;

  // table state
  logic [RowBits-1:0]  row_ext, cur_r;
  logic [ColBits-1:0]  col_ext, cur_c;
  logic [CBits-1:0]    norm_c;
  logic [31:0]         drop_cnt;
  logic [CntBits-1:0]  clr_cnt, walk_cnt;

  // walk accumulators and pipeline
  logic                p1_v, p2_v;
  logic [AddrBits-1:0] p1_idx;
  logic [CntBits-1:0]  acc_n;
  logic [SumBits-1:0]  acc_s;
  logic [SqBits-1:0]   acc_q;

  // finish results
  logic [RootBits-1:0] mean;
  logic [24:0]         nn;
  logic [76:0]         nq;

  // shared registered multiplier
  logic [31:0] mx, my;
  logic [63:0] mprod;

  // bit-serial units
  logic [DivBits-1:0]  div_n;
  logic [CBits-1:0]    div_r, div_d;
  logic [6:0]          div_cnt;
  logic                div_cell;
  logic [MulBits-1:0]  mul_a, mul_p;
  logic [MulIters-1:0] mul_b;
  logic [5:0]          mul_cnt;
  logic [SqrtBits-1:0] sq_v;
  logic [RootBits-1:0] sq_root;
  logic [CBits-1:0]    sq_rem;
  logic [5:0]          sq_cnt;

  logic [NormBits-1:0] norm_val;

  // RAM
  logic                ram_we;
  logic [AddrBits-1:0] ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;
  logic                rd_pres;
  logic [ValueBits-1:0] rd_val;
  assign rd_pres = ram_rdata[ValueBits];
  assign rd_val  = ram_rdata[ValueBits-1:0];

  pwsn_ram #(.Width(WordBits), .Depth(Wells)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // new well value for an add
  logic [ValueBits-1:0] old_v, sat_size, new_v, sat_contrib;
  logic [57:0]          contrib;
  logic [32:0]          pass_sum;
  logic [ValueBits:0]   tot_sum;
  always_comb begin
    old_v       = rd_pres ? rd_val : '0;
    sat_size    = (add_size > 32'(ValueMax)) ? ValueMax : add_size[ValueBits-1:0];
    contrib     = add_hp ? mprod[57:0] : 58'(add_size);
    sat_contrib = (contrib > 58'(ValueMax)) ? ValueMax : contrib[ValueBits-1:0];
    pass_sum    = 33'(old_v) + (add_hp ? 33'(add_np) : 33'd1);
    tot_sum     = {1'b0, sat_contrib} + {1'b0, old_v};
    case (mode)
      MODE_PASSES: new_v = (pass_sum > 33'(ValueMax)) ? ValueMax : pass_sum[ValueBits-1:0];
      MODE_TOTAL:  new_v = tot_sum[ValueBits] ? ValueMax : tot_sum[ValueBits-1:0];
      default:     new_v = (!rd_pres || old_v < sat_size) ? sat_size : old_v;
    endcase
  end

  always_comb begin
    if (state == S_FIN_WALK) begin
      mx = 32'(rd_val);
      my = 32'(rd_val);
    end else begin
      mx = 32'(sat_size);
      my = add_np;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = add_idx;
    ram_wdata = {1'b1, new_v};
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt[AddrBits-1:0];
      ram_wdata = '0;
    end else if (state == S_ADD_WR) begin
      ram_we = 1'b1;
    end
    if (state == S_FIN_WALK)
      ram_raddr = walk_cnt[AddrBits-1:0];
    else if (state == S_RD_RD || state == S_RD_CHK)
      ram_raddr = {cur_r, cur_c};
    else
      ram_raddr = add_idx;
  end

  // serial step values
  logic [CBits:0]   div_r2;
  logic             div_ge;
  logic [CBits+1:0] sq_r2, sq_trial;
  logic             sq_ge;
  logic [92:0]      var_num;
  logic             cell_last;
  always_comb begin
    div_r2   = {div_r, div_n[DivBits-1]};
    div_ge   = div_r2 >= {1'b0, div_d};
    sq_r2    = {sq_rem, sq_v[SqrtBits-1 -: 2]};
    sq_trial = (CBits+2)'({sq_root, 2'b01});
    sq_ge    = sq_r2 >= sq_trial;
    var_num  = {nq - mul_p[76:0], 16'b0};
    cell_last = (cur_r == row_ext) && (cur_c == col_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      phase         <= P_MEAN;
      mode          <= MODE_MAX;
      clr_cnt       <= '0;
      row_ext       <= '0;
      col_ext       <= '0;
      norm_c        <= '0;
      cur_r         <= '0;
      cur_c         <= '0;
      drop_cnt      <= '0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      div_cell      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we)
        mode <= (mode_t'(cfg_wdata) == MODE_RSVD) ? MODE_MAX : mode_t'(cfg_wdata);
      // a new cell loaded in S_OUT takes the place of the one leaving
      if (m_axis_tvalid && m_axis_tready && state != S_OUT)
        m_axis_tvalid <= 1'b0;
      mprod <= 64'(mx * my);

      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CntBits'(Wells - 1))
            state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc) begin
            add_idx  <= {in_row[RowBits-1:0], in_col[ColBits-1:0]};
            add_size <= in_size;
            add_hp   <= in_hp;
            add_np   <= in_np;
            unique case (op_t'(s_axis_tuser))
              OP_ADD: begin
                if (in_row[15:RowBits] != '0 || in_col[15:ColBits] != '0) begin
                  if (drop_cnt != '1)
                    drop_cnt <= drop_cnt + 1'b1;
                end else begin
                  state <= S_ADD_RD;
                end
              end
              OP_FINISH: begin
                row_ext  <= '0;
                col_ext  <= '0;
                cur_r    <= '0;
                cur_c    <= '0;
                walk_cnt <= '0;
                acc_n    <= '0;
                acc_s    <= '0;
                acc_q    <= '0;
                p1_v     <= 1'b0;
                p2_v     <= 1'b0;
                state    <= S_FIN_WALK;
              end
              OP_READ: state <= S_RD_RD;
              OP_CLEAR: begin
                row_ext  <= '0;
                col_ext  <= '0;
                norm_c   <= '0;
                cur_r    <= '0;
                cur_c    <= '0;
                drop_cnt <= '0;
                clr_cnt  <= '0;
                state    <= S_CLR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_ADD_RD:  state <= S_ADD_MUL;
        S_ADD_MUL: state <= S_ADD_WR;   // product registers here
        S_ADD_WR:  state <= S_IDLE;

        S_FIN_WALK: begin
          // stage 0: issue address
          p1_v   <= !walk_cnt[AddrBits];
          p1_idx <= walk_cnt[AddrBits-1:0];
          if (!walk_cnt[AddrBits])
            walk_cnt <= walk_cnt + 1'b1;
          // stage 1: data back, square under way
          p2_v <= p1_v && rd_pres;
          if (p1_v && rd_pres) begin
            acc_n   <= acc_n + 1'b1;
            acc_s   <= acc_s + SumBits'(rd_val);
            row_ext <= p1_idx[AddrBits-1:ColBits];
            if (p1_idx[ColBits-1:0] > col_ext)
              col_ext <= p1_idx[ColBits-1:0];
          end
          // stage 2: sum of squares
          if (p2_v)
            acc_q <= acc_q + SqBits'(mprod[2*ValueBits-1:0]);
          if (walk_cnt[AddrBits] && !p1_v && !p2_v) begin
            if (acc_n == '0) begin
              norm_c <= '0;
              state  <= S_IDLE;
            end else begin
              phase <= P_MEAN;
              state <= S_SEQ;
            end
          end
        end

        S_SEQ: begin
          unique case (phase)
            P_MEAN: begin
              div_n    <= DivBits'({acc_s, 8'b0});
              div_r    <= '0;
              div_d    <= CBits'(acc_n);
              div_cnt  <= 7'(DivBits - 1);
              div_cell <= 1'b0;
              phase    <= P_NN;
              state    <= S_DIV;
            end
            P_NN: begin
              mean    <= div_n[RootBits-1:0];
              mul_a   <= MulBits'(acc_n);
              mul_b   <= MulIters'(acc_n);
              mul_p   <= '0;
              mul_cnt <= 6'(MulIters - 1);
              phase   <= P_NQ;
              state   <= S_MUL;
            end
            P_NQ: begin
              nn      <= mul_p[24:0];
              mul_a   <= MulBits'(acc_q);
              mul_b   <= MulIters'(acc_n);
              mul_p   <= '0;
              mul_cnt <= 6'(MulIters - 1);
              phase   <= P_SS;
              state   <= S_MUL;
            end
            P_SS: begin
              nq      <= mul_p[76:0];
              mul_a   <= MulBits'(acc_s);
              mul_b   <= acc_s;
              mul_p   <= '0;
              mul_cnt <= 6'(MulIters - 1);
              phase   <= P_VAR;
              state   <= S_MUL;
            end
            P_VAR: begin
              div_n    <= DivBits'(var_num);
              div_r    <= '0;
              div_d    <= CBits'(nn);
              div_cnt  <= 7'(DivBits - 1);
              div_cell <= 1'b0;
              phase    <= P_SQRT;
              state    <= S_DIV;
            end
            P_SQRT: begin
              sq_v    <= div_n[SqrtBits-1:0];
              sq_root <= '0;
              sq_rem  <= '0;
              sq_cnt  <= 6'(RootBits - 1);
              phase   <= P_DONE;
              state   <= S_SQRT;
            end
            P_DONE: begin
              norm_c <= CBits'(mean) + CBits'({sq_root, 1'b0});
              state  <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end

        S_MUL: begin
          if (mul_b[0])
            mul_p <= mul_p + mul_a;
          mul_a   <= {mul_a[MulBits-2:0], 1'b0};
          mul_b   <= {1'b0, mul_b[MulIters-1:1]};
          mul_cnt <= mul_cnt - 1'b1;
          if (mul_cnt == '0)
            state <= S_SEQ;
        end

        S_DIV: begin
          div_r   <= div_ge ? CBits'(div_r2 - {1'b0, div_d}) : div_r2[CBits-1:0];
          div_n   <= {div_n[DivBits-2:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0)
            state <= div_cell ? S_OUT : S_SEQ;
        end

        S_SQRT: begin
          sq_rem  <= sq_ge ? CBits'(sq_r2 - sq_trial) : sq_r2[CBits-1:0];
          sq_root <= {sq_root[RootBits-2:0], sq_ge};
          sq_v    <= {sq_v[SqrtBits-3:0], 2'b00};
          sq_cnt  <= sq_cnt - 1'b1;
          if (sq_cnt == '0)
            state <= S_SEQ;
        end

        S_RD_RD: state <= S_RD_CHK;

        S_RD_CHK: begin
          if (!rd_pres) begin
            norm_val <= '0;
            state    <= S_OUT;
          end else if (CBits'({rd_val, 8'b0}) >= norm_c) begin
            norm_val <= NormBits'(65536);
            state    <= S_OUT;
          end else begin
            // quotient stays below 2^16 here
            div_n    <= DivBits'({rd_val, 24'b0});
            div_r    <= '0;
            div_d    <= norm_c;
            div_cnt  <= 7'(DivBits - 1);
            div_cell <= 1'b1;
            state    <= S_DIV;
          end
        end

        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tlast  <= cell_last;
            m_axis_tdata  <= OutDataW'({drop_cnt,
                                        7'(col_ext) + 7'd1,
                                        7'(row_ext) + 7'd1,
                                        div_cell ? div_n[NormBits-1:0] : norm_val,
                                        cur_c, cur_r});
            div_cell <= 1'b0;
            if (cur_c == col_ext) begin
              cur_c <= '0;
              cur_r <= (cur_r == row_ext) ? '0 : cur_r + 1'b1;
            end else begin
              cur_c <= cur_c + 1'b1;
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
